@@ hw/rtl/number_to_ascii_formatter_core_assert.svh @@
// Assertion macros for the number to ASCII formatter.
`ifndef NUMBER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define NUMBER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define NAF_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define NAF_ASSERT_NEXT(label, clk, rstn, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define NAF_ASSERT_IMPL(label, clk, rstn, prop)
`define NAF_ASSERT_NEXT(label, clk, rstn, cond, nxt)
`endif
`endif

@@ hw/rtl/naf_pkg.sv @@
package naf_pkg;
    localparam int MaxWidth  = 32;
    localparam int MaxFrac   = 12;
    localparam int IntDigits = 10;
    localparam int QDepth    = 2;

    // Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit value.
    localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        OP_SDEC = 3'd0, OP_UDEC = 3'd1, OP_HEX = 3'd2,
        OP_XHEX = 3'd3, OP_UFIX = 3'd4, OP_SFIX = 3'd5
    } op_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] mag;
        logic        neg;
        logic [5:0]  width;
        logic [3:0]  prec;
        logic [7:0]  pad;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
    endfunction
endpackage

@@ hw/rtl/naf_front.sv @@
module naf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       in_op,
    input  logic [31:0]      in_value,
    input  logic [5:0]       in_width,
    input  logic [3:0]       in_prec,
    input  logic             in_pad_zero,
    output logic             q_valid,
    input  logic             q_ready,
    output naf_pkg::cmd_t    q_cmd
);
    import naf_pkg::*;

    cmd_t          mem [QDepth];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    cmd_t          c;
    logic          neg;
    logic [31:0]   mag;

    always_comb begin
        neg = 1'b0;
        mag = in_value;
        if ((in_op == OP_SDEC || in_op == OP_SFIX) && in_value[31]) begin
            neg = 1'b1;
            mag = 32'd0 - in_value;
        end
        if (in_op == OP_SFIX) mag = {mag[30:0], 1'b0};
        c.op    = in_op;
        c.mag   = mag;
        c.neg   = neg;
        c.width = (in_width > 6'(MaxWidth)) ? 6'(MaxWidth) : in_width;
        c.prec  = (in_prec > 4'(MaxFrac)) ? 4'(MaxFrac) : in_prec;
        c.pad   = (in_pad_zero && in_op != OP_SDEC) ? 8'h30 : 8'h20;
    end

    assign in_ready = (cnt_reg != 2'(QDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem[wp_reg] <= c;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
        end
    end
endmodule

@@ hw/rtl/naf_back.sv @@
module naf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  naf_pkg::cmd_t  q_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic           out_last
);
    import naf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FRAC, S_ROUND, S_INT, S_HEX,
        S_PAD, S_SIGN, S_IDIG, S_DOT, S_FDIG, S_XHEX
    } state_t;

    state_t       state_reg;
    cmd_t         cmd_reg;
    // Integer digits least significant first, fraction digits most significant first.
    logic [3:0]   idig_reg [IntDigits];
    logic [3:0]   frac_reg [MaxFrac];
    logic [3:0]   ilen_reg;
    logic [3:0]   ii_reg;
    logic [31:0]  v_reg;
    logic [15:0]  f_reg;
    logic [3:0]   fi_reg;
    logic         carry_reg;
    logic [3:0]   ci_reg;
    logic [5:0]   pads_reg;
    logic [5:0]   xi_reg;
    logic [7:0]   char_reg;
    logic         last_reg;
    logic         valid_reg;

    logic [63:0]  recip;
    logic [31:0]  q10;
    logic [3:0]   r10;
    logic [19:0]  f10;
    logic         is_fixed;
    logic         has_frac;
    logic [5:0]   body_len;
    logic [5:0]   pad_count;
    state_t       first_state;
    logic [3:0]   xdig;
    logic         emit_state;
    logic         emitting;
    logic [7:0]   char_next;
    logic         last_next;

    // Divide by ten through a reciprocal multiply.
    assign recip = 64'(v_reg) * 64'(Recip10);
    assign q10   = {3'd0, recip[63:35]};
    assign r10   = 4'(v_reg - q10 * 32'd10);

    assign f10      = {4'd0, f_reg} * 20'd10;
    assign is_fixed = (cmd_reg.op == OP_UFIX) || (cmd_reg.op == OP_SFIX);
    assign has_frac = is_fixed && (cmd_reg.prec != 4'd0);
    // Evaluated on the cycle that writes the last integer digit.
    assign body_len = 6'(ilen_reg) + 6'd1 + 6'(cmd_reg.neg)
                    + (has_frac ? 6'(cmd_reg.prec) + 6'd1 : 6'd0);
    assign pad_count   = (cmd_reg.width > body_len) ? cmd_reg.width - body_len : 6'd0;
    assign first_state = (pad_count != 6'd0) ? S_PAD : (cmd_reg.neg ? S_SIGN : S_IDIG);
    assign xdig = (xi_reg < 6'd8) ? cmd_reg.mag[{xi_reg[2:0], 2'b00} +: 4] : 4'd0;

    always_comb begin
        char_next  = 8'h30;
        last_next  = 1'b0;
        emit_state = 1'b1;
        unique case (state_reg)
            S_PAD:  char_next = cmd_reg.pad;
            S_SIGN: char_next = 8'h2D;
            S_IDIG: begin
                char_next = hex_char(idig_reg[ii_reg]);
                last_next = (ii_reg == 4'd0) && !has_frac;
            end
            S_DOT:  char_next = 8'h2E;
            S_FDIG: begin
                char_next = 8'h30 + {4'd0, frac_reg[fi_reg]};
                last_next = (fi_reg == cmd_reg.prec - 4'd1);
            end
            S_XHEX: begin
                char_next = hex_char(xdig);
                last_next = (xi_reg == 6'd0);
            end
            default: emit_state = 1'b0;
        endcase
    end

    assign emitting  = emit_state && (!valid_reg || out_ready);
    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            char_reg  <= 8'd0;
            last_reg  <= 1'b0;
        end else begin
            if (emitting) begin
                valid_reg <= 1'b1;
                char_reg  <= char_next;
                last_reg  <= last_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (q_valid) begin
                    cmd_reg  <= q_cmd;
                    ilen_reg <= 4'd0;
                    f_reg    <= q_cmd.mag[15:0];
                    fi_reg   <= 4'd0;
                    xi_reg   <= q_cmd.width - 6'd1;
                    v_reg    <= (q_cmd.op == OP_UFIX || q_cmd.op == OP_SFIX)
                                ? {16'd0, q_cmd.mag[31:16]} : q_cmd.mag;
                    unique case (q_cmd.op)
                        OP_SDEC, OP_UDEC: state_reg <= S_INT;
                        OP_HEX:           state_reg <= S_HEX;
                        // Width zero produces no characters at all.
                        OP_XHEX: if (q_cmd.width != 6'd0) state_reg <= S_XHEX;
                        OP_UFIX, OP_SFIX: state_reg <= S_FRAC;
                        default: ;
                    endcase
                end
                S_FRAC: begin
                    if (fi_reg == cmd_reg.prec) begin
                        // One more digit decides rounding, half up.
                        carry_reg <= (f10[19:16] > 4'd4);
                        ci_reg    <= cmd_reg.prec;
                        state_reg <= S_ROUND;
                    end else begin
                        frac_reg[fi_reg] <= f10[19:16];
                        f_reg  <= f10[15:0];
                        fi_reg <= fi_reg + 4'd1;
                    end
                end
                S_ROUND: begin
                    // Ripple the carry from the least significant fraction digit.
                    if (ci_reg == 4'd0 || !carry_reg) begin
                        v_reg     <= v_reg + 32'(carry_reg);
                        state_reg <= S_INT;
                    end else begin
                        if (frac_reg[ci_reg - 4'd1] == 4'd9) begin
                            frac_reg[ci_reg - 4'd1] <= 4'd0;
                        end else begin
                            frac_reg[ci_reg - 4'd1] <= frac_reg[ci_reg - 4'd1] + 4'd1;
                            carry_reg <= 1'b0;
                        end
                        ci_reg <= ci_reg - 4'd1;
                    end
                end
                S_INT: begin
                    idig_reg[ilen_reg] <= r10;
                    v_reg <= q10;
                    if (q10 == 32'd0) begin
                        pads_reg  <= pad_count;
                        ii_reg    <= ilen_reg;
                        state_reg <= first_state;
                    end else begin
                        ilen_reg <= ilen_reg + 4'd1;
                    end
                end
                S_HEX: begin
                    idig_reg[ilen_reg] <= v_reg[3:0];
                    v_reg <= v_reg >> 4;
                    if (v_reg[31:4] == 28'd0 || ilen_reg == 4'd7) begin
                        pads_reg  <= pad_count;
                        ii_reg    <= ilen_reg;
                        state_reg <= first_state;
                    end else begin
                        ilen_reg <= ilen_reg + 4'd1;
                    end
                end
                S_PAD: if (emitting) begin
                    if (pads_reg == 6'd1) state_reg <= cmd_reg.neg ? S_SIGN : S_IDIG;
                    pads_reg <= pads_reg - 6'd1;
                end
                S_SIGN: if (emitting) state_reg <= S_IDIG;
                S_IDIG: if (emitting) begin
                    if (ii_reg == 4'd0) state_reg <= has_frac ? S_DOT : S_IDLE;
                    else ii_reg <= ii_reg - 4'd1;
                end
                S_DOT: if (emitting) begin
                    fi_reg    <= 4'd0;
                    state_reg <= S_FDIG;
                end
                S_FDIG: if (emitting) begin
                    if (fi_reg == cmd_reg.prec - 4'd1) state_reg <= S_IDLE;
                    else fi_reg <= fi_reg + 4'd1;
                end
                S_XHEX: if (emitting) begin
                    if (xi_reg == 6'd0) state_reg <= S_IDLE;
                    else xi_reg <= xi_reg - 6'd1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/number_to_ascii_formatter_core.sv @@
// Channel | Dir | tdata fields (low bit up)                                 | tlast
// s_      | in  | opcode[2:0] value[34:3] width[40:35] prec[44:41] pad[45] | -
// m_      | out | character[7:0]                                            | last
// The back end takes a queued command; for fixed point it computes the fraction
// digits and one more digit for rounding, then ripples the carry through the
// fraction digits; it then computes the integer digits (reciprocal divide by
// ten) or the hex digits. Characters then leave one per cycle while m_tready is
// high. A two-entry command queue takes the next value while the current one
// runs. Reset is synchronous; the output register holds its character while
// m_tready is low.
module number_to_ascii_formatter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode, value, field_width, precision, pad_zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character
    output logic        m_tlast
);
    import naf_pkg::*;
`include "number_to_ascii_formatter_core_assert.svh"

    logic  qv, qr;
    cmd_t  qc;

    naf_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[2:0]), .in_value(s_tdata[34:3]), .in_width(s_tdata[40:35]),
        .in_prec(s_tdata[44:41]), .in_pad_zero(s_tdata[45]),
        .q_valid(qv), .q_ready(qr), .q_cmd(qc)
    );

    naf_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(qv), .q_ready(qr), .q_cmd(qc),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_char(m_tdata), .out_last(m_tlast)
    );

    `NAF_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `NAF_ASSERT_NEXT(a_last_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tlast))
    `NAF_ASSERT_IMPL(a_known, aclk, aresetn, m_tvalid |-> !$isunknown(m_tdata))
endmodule

@@ tb/number_to_ascii_formatter_core_tb.sv @@
`timescale 1ns / 100ps

module number_to_ascii_formatter_core_tb;
    import naf_pkg::*;

    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    char_t char_queue[$];
    int    error_count;
    int    idle_cycles;
    bit    sender_busy;

    number_to_ascii_formatter_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + 8'(d);
        end else begin
            c = 8'h61 + 8'(d) - 8'd10;
        end
        return c;
    endfunction

    // Builds the text for one value, appends it to char_queue with the last flag.
    task automatic predict_text(input op_t op, input logic [31:0] value,
                                input logic [5:0] fwidth, input logic [3:0] prec_in,
                                input bit pad_zero);
        logic [7:0]  text[$];
        logic [7:0]  body[$];      // digits, least significant first
        logic [7:0]  pad;
        logic [31:0] mag;
        logic [31:0] f;
        logic [31:0] ipart;
        logic [3:0]  frac[12];
        int          width;
        int          prec;
        int          carry;
        bit          neg;
        bit          fixed;
        width = (fwidth > 6'd32) ? 32 : int'(fwidth);
        prec = (prec_in > 4'd12) ? 12 : int'(prec_in);
        pad = pad_zero ? 8'h30 : 8'h20;
        neg = 1'b0;
        fixed = 1'b0;
        mag = value;
        case (op)
            OP_SDEC: begin
                neg = value[31];
                mag = neg ? -value : value;
                pad = 8'h20;
            end
            OP_UDEC: ;
            OP_HEX: begin
                do begin
                    body.push_back(digit_char(mag[3:0]));
                    mag = mag >> 4;
                end while (mag != 0 && body.size() < 8);
            end
            OP_XHEX: begin
                for (int pos = width - 1; pos >= 0; pos--) begin
                    text.push_back(digit_char(pos < 8 ? value[4*pos +: 4] : 4'd0));
                end
            end
            OP_UFIX: fixed = 1'b1;
            OP_SFIX: begin
                fixed = 1'b1;
                neg = value[31];
                mag = (neg ? -value : value) << 1;
            end
            default: ;
        endcase
        ipart = mag;
        if (fixed) begin
            f = mag;
            for (int i = 0; i < prec; i++) begin
                f = (f & 32'h0000ffff) * 10;
                frac[i] = f[19:16];
            end
            f = (f & 32'h0000ffff) * 10;
            carry = (f[31:16] > 4) ? 1 : 0;
            for (int j = prec - 1; j >= 0 && carry != 0; j--) begin
                if (frac[j] >= 9) begin
                    frac[j] = 0;
                end else begin
                    frac[j]++;
                    carry = 0;
                end
            end
            for (int j = prec - 1; j >= 0; j--) body.push_back(digit_char(frac[j]));
            if (prec > 0) body.push_back(8'h2e);
            ipart = (mag >> 16) + carry;
        end
        if (op inside {OP_SDEC, OP_UDEC, OP_UFIX, OP_SFIX}) begin
            // Decimal conversion runs until the quotient is zero; a 32-bit value gives at most ten digits.
            do begin
                body.push_back(digit_char(4'(ipart % 10)));
                ipart = ipart / 10;
            end while (ipart != 0);
        end
        if (op inside {OP_SDEC, OP_UDEC, OP_HEX, OP_UFIX, OP_SFIX}) begin
            for (int k = body.size() + (neg ? 1 : 0); k < width; k++) text.push_back(pad);
            if (neg) text.push_back(8'h2d);
            for (int k = body.size() - 1; k >= 0; k--) text.push_back(body[k]);
        end
        for (int k = 0; k < text.size() && k < 32; k++) begin
            char_queue.push_back('{character: text[k],
                                   last: (k == text.size() - 1 || k == 31)});
        end
    endtask

    task automatic send_value(input op_t op, input logic [31:0] value,
                              input logic [5:0] fwidth, input logic [3:0] prec,
                              input bit pad_zero);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pad_zero, prec, fwidth, value, 3'(op)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_text(op, value, fwidth, prec, pad_zero);
        @(negedge aclk);
    endtask

    task automatic send_raw(input logic [2:0] opbits, input logic [31:0] value,
                            input logic [5:0] fwidth, input logic [3:0] prec,
                            input bit pad_zero);
        send_value(op_t'(opbits), value, fwidth, prec, pad_zero);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (char_queue.size() != 0);
    endtask

    task automatic test_decimal();
        send_value(OP_SDEC, 32'h0000_0000, 6'd0, 4'd0, 1'b0);
        send_value(OP_SDEC, 32'h8000_0000, 6'd14, 4'd0, 1'b1);
        send_value(OP_SDEC, 32'hffff_ffff, 6'd5, 4'd0, 1'b1);
        send_value(OP_SDEC, 32'h7fff_ffff, 6'd63, 4'd0, 1'b0);
        send_value(OP_UDEC, 32'hffff_ffff, 6'd12, 4'd15, 1'b1);
        send_value(OP_UDEC, 32'd0, 6'd40, 4'd0, 1'b0);
    endtask

    task automatic test_hex();
        send_value(OP_HEX, 32'h0000_0000, 6'd4, 4'd0, 1'b1);
        send_value(OP_HEX, 32'hdead_beef, 6'd10, 4'd0, 1'b0);
        send_value(OP_XHEX, 32'h1234_abcd, 6'd0, 4'd0, 1'b0);
        send_value(OP_XHEX, 32'h1234_abcd, 6'd12, 4'd0, 1'b0);
        send_value(OP_XHEX, 32'hfedc_ba98, 6'd63, 4'd15, 1'b1);
        send_value(OP_XHEX, 32'h0000_000f, 6'd1, 4'd0, 1'b0);
    endtask

    task automatic test_fixed();
        send_value(OP_UFIX, 32'h0001_8000, 6'd0, 4'd0, 1'b0);
        send_value(OP_UFIX, 32'hffff_ffff, 6'd32, 4'd15, 1'b1);
        send_value(OP_UFIX, 32'h0000_fffe, 6'd8, 4'd3, 1'b0);
        send_value(OP_UFIX, 32'h0000_0001, 6'd0, 4'd12, 1'b0);
        send_value(OP_SFIX, 32'h8000_0000, 6'd6, 4'd2, 1'b1);
        send_value(OP_SFIX, 32'hffff_c000, 6'd10, 4'd4, 1'b1);
        send_value(OP_SFIX, 32'h7fff_ffff, 6'd0, 4'd13, 1'b0);
        send_value(OP_SFIX, 32'hffff_ffff, 6'd20, 4'd1, 1'b0);
    endtask

    task automatic test_unused_opcodes();
        send_raw(3'd6, 32'hffff_ffff, 6'd32, 4'd15, 1'b1);
        send_raw(3'd7, 32'h5555_aaaa, 6'd63, 4'd0, 1'b0);
        send_value(OP_UDEC, 32'd7, 6'd0, 4'd0, 1'b0);
    endtask

    task automatic test_random(input int count);
        logic [31:0] value;
        logic [5:0]  fwidth;
        for (int n = 0; n < count; n++) begin
            value = $urandom();
            case ($urandom_range(0, 3))
                0: value = value >> $urandom_range(0, 31);
                1: value = value | 32'h8000_0000;
                default: ;
            endcase
            fwidth = ($urandom_range(0, 4) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 16));
            send_raw(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5)),
                     value, fwidth, 4'($urandom()), 1'($urandom()));
            if (n == count / 2) wait_drained();
        end
    endtask

    // Result checker with a random stall on the receive side.
    initial begin
        int stall;
        char_t exp_char;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (char_queue.size() == 0) begin
                $display("%0t: unexpected character expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                exp_char = char_queue.pop_front();
                if (m_tdata !== exp_char.character) begin
                    $display("%0t: character mismatch expected %h actual %h",
                             $time, exp_char.character, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_char.last) begin
                    $display("%0t: last mismatch expected %b actual %b",
                             $time, exp_char.last, m_tlast);
                    error_count++;
                end
            end
            @(negedge aclk);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (sender_busy || char_queue.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        sender_busy = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_decimal();
        test_hex();
        test_fixed();
        test_unused_opcodes();
        test_random(310);
        wait_drained();
        sender_busy = 1'b0;
        repeat (100) @(negedge aclk);
        if (error_count == 0 && char_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
